@@ src/ccc_pkg.sv @@
package ccc_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Result kinds carried on m_tuser
    localparam logic [2:0] OUT_NEW   = 3'd0;
    localparam logic [2:0] OUT_FULL  = 3'd1;
    localparam logic [2:0] OUT_END   = 3'd2;
    localparam logic [2:0] OUT_CONT  = 3'd3;
    localparam logic [2:0] OUT_HEX   = 3'd4;
    localparam logic [2:0] OUT_SPACE = 3'd5;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_FAIL = 2'd2
    } act_kind_t;

    // What the parser asks for on one accepted byte
    typedef struct packed {
        act_kind_t   kind;
        logic [23:0] code;
        logic [2:0]  outcome;
    } action_t;

    // Lookup probe that walks the cell row
    typedef struct packed {
        logic             valid;
        logic [23:0]      code;
        logic             hit;
        logic             placed;
        logic [CNT_W-1:0] remaining;
    } probe_t;

endpackage

@@ src/ccc_parser.sv @@
module ccc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              end_of_file,
    output ccc_pkg::action_t  action
);

    typedef enum logic [15:0] {
        PH_START   = 16'h0001,
        PH_MARK2   = 16'h0002,
        PH_IDLE    = 16'h0004,
        PH_WIDE_HI = 16'h0008,
        PH_U2      = 16'h0010,
        PH_U3      = 16'h0020,
        PH_H1      = 16'h0040,
        PH_X1      = 16'h0080,
        PH_X2      = 16'h0100,
        PH_T       = 16'h0200,
        PH_Q       = 16'h0400,
        PH_S2A     = 16'h0800,
        PH_S2B     = 16'h1000,
        PH_S3SP    = 16'h2000,
        PH_S3A     = 16'h4000,
        PH_S3B     = 16'h8000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] partial_reg, partial_next;
    logic [8:0]  pending_reg, pending_next;
    logic        wide_reg, wide_next;
    logic        halted_reg, halted_next;
    ccc_pkg::action_t act;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        return v;
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        return {hex_val(hi), hex_val(lo)};
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return c >= 8'h80 && c <= 8'hBF;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic [23:0] to_utf8(input logic [15:0] u);
        logic [23:0] r;
        if (|u[15:11])
            r = {4'hE, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]};
        else if (|u[10:8])
            r = {8'h00, 3'b110, u[10:6], 2'b10, u[5:0]};
        else
            r = {16'h0000, u[7:0]};
        return r;
    endfunction

    // Request a store, dropping codes that are never collected
    function automatic ccc_pkg::action_t add_code(input logic [23:0] c);
        ccc_pkg::action_t a;
        a.kind    = ccc_pkg::ACT_ADD;
        a.code    = c;
        a.outcome = ccc_pkg::OUT_NEW;
        if (c == 24'h0 || c == 24'h0A || c == 24'h0D || c == 24'h09)
            a.kind = ccc_pkg::ACT_NONE;
        return a;
    endfunction

    function automatic ccc_pkg::action_t fail_act(input logic [2:0] o);
        ccc_pkg::action_t a;
        a.kind    = ccc_pkg::ACT_FAIL;
        a.code    = 24'h0;
        a.outcome = o;
        return a;
    endfunction

    function automatic logic in_token(input phase_t p);
        return !(p == PH_START || p == PH_MARK2 || p == PH_IDLE || p == PH_WIDE_HI);
    endfunction

    // Close the token that is open in phase p
    function automatic ccc_pkg::action_t finish(input phase_t p, input logic [7:0] lead,
                                                input logic [8:0] pend);
        ccc_pkg::action_t a;
        a.kind    = ccc_pkg::ACT_NONE;
        a.code    = 24'h0;
        a.outcome = ccc_pkg::OUT_NEW;
        case (p)
            PH_H1:
                a = add_code({16'h0, pend[7:0]});
            PH_T:
                if (pend[8] || lead >= 8'hC0)
                    a = fail_act(ccc_pkg::OUT_HEX);
                else
                    a = add_code({16'h0, lead});
            PH_S2A:
                a = add_code({16'h0, lead});
            PH_U2, PH_U3, PH_X1, PH_X2, PH_Q, PH_S2B, PH_S3SP, PH_S3A, PH_S3B:
                a = fail_act(ccc_pkg::OUT_END);
            default:
                a.kind = ccc_pkg::ACT_NONE;
        endcase
        return a;
    endfunction

    // Parse one byte
    always_comb
    begin
        phase_t     cur;
        logic [7:0] b;
        logic [7:0] lead;
        logic [7:0] v8;
        logic [15:0] v16;
        ccc_pkg::action_t f;

        b    = in_byte;
        lead = partial_reg[23:16];
        v8   = hex_pair(pending_reg[7:0], b);
        v16  = {b, pending_reg[7:0]};
        f    = '0;
        act.kind    = ccc_pkg::ACT_NONE;
        act.code    = 24'h0;
        act.outcome = ccc_pkg::OUT_NEW;

        partial_next = partial_reg;
        pending_next = pending_reg;
        wide_next    = wide_reg;
        halted_next  = halted_reg;

        cur = phase_reg;
        if (cur == PH_START && b != 8'hFF)
            cur = PH_IDLE;
        phase_next = cur;

        if (cur == PH_START)
        begin
            phase_next = PH_MARK2;
        end
        else if (cur == PH_MARK2)
        begin
            wide_next  = (b == 8'hFE);
            phase_next = PH_IDLE;
        end
        else if (cur == PH_IDLE)
        begin
            if (wide_reg)
            begin
                pending_next = {1'b0, b};
                phase_next   = PH_WIDE_HI;
            end
            else if (is_space(b))
            begin
                phase_next = PH_IDLE;
            end
            else if (b >= 8'hC0)
            begin
                partial_next = {b, 16'h0};
                phase_next   = PH_U2;
            end
            else if (is_hex(b))
            begin
                pending_next = {1'b0, b};
                phase_next   = PH_H1;
            end
            else
            begin
                act = add_code({16'h0, b});
            end
        end
        else if (cur == PH_WIDE_HI)
        begin
            phase_next = PH_IDLE;
            if (v16 == 16'h0)
                halted_next = 1'b1;
            else if (!(v16[15:8] == 8'h0 && is_space(v16[7:0])))
                act = add_code(to_utf8(v16));
        end
        else if (b == 8'h00)
        begin
            act        = finish(cur, lead, pending_reg);
            phase_next = PH_IDLE;
        end
        else
        begin
            case (cur)
                PH_U2:
                    if (!is_cont(b))
                        act = fail_act(ccc_pkg::OUT_CONT);
                    else if (lead >= 8'hE0)
                    begin
                        partial_next[15:8] = b;
                        phase_next = PH_U3;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code({8'h0, lead, b});
                    end
                PH_U3:
                    if (!is_cont(b))
                        act = fail_act(ccc_pkg::OUT_CONT);
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code({partial_reg[23:8], b});
                    end
                PH_H1:
                    if (pending_reg[7:0] == 8'h30 && b == 8'h78)
                    begin
                        pending_next = 9'h100;
                        phase_next   = PH_X1;
                    end
                    else if (is_hex(b))
                    begin
                        partial_next = {v8, 16'h0};
                        pending_next = 9'h000;
                        phase_next   = PH_T;
                    end
                    else
                        phase_next = PH_IDLE;
                PH_X1:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else
                    begin
                        pending_next = {1'b1, b};
                        phase_next   = PH_X2;
                    end
                PH_X2:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else
                    begin
                        partial_next = {v8, 16'h0};
                        pending_next = 9'h100;
                        phase_next   = PH_T;
                    end
                PH_T:
                    if (is_hex(b))
                    begin
                        pending_next = {pending_reg[8], b};
                        phase_next   = PH_Q;
                    end
                    else if (lead >= 8'hC0)
                    begin
                        if (b != 8'h20)
                            act = fail_act(ccc_pkg::OUT_SPACE);
                        else
                            phase_next = PH_S2A;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code({16'h0, lead});
                    end
                PH_Q:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code(to_utf8({lead, v8}));
                    end
                PH_S2A, PH_S3A:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else
                    begin
                        pending_next = {1'b0, b};
                        phase_next   = (cur == PH_S2A) ? PH_S2B : PH_S3B;
                    end
                PH_S2B:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else if (!is_cont(v8))
                        act = fail_act(ccc_pkg::OUT_CONT);
                    else if (lead >= 8'hE0)
                    begin
                        partial_next[15:8] = v8;
                        phase_next = PH_S3SP;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code({8'h0, lead, v8});
                    end
                PH_S3SP:
                    if (b != 8'h20)
                        act = fail_act(ccc_pkg::OUT_SPACE);
                    else
                        phase_next = PH_S3A;
                PH_S3B:
                    if (!is_hex(b))
                        act = fail_act(ccc_pkg::OUT_HEX);
                    else if (!is_cont(v8))
                        act = fail_act(ccc_pkg::OUT_CONT);
                    else
                    begin
                        phase_next = PH_IDLE;
                        act = add_code({partial_reg[23:8], v8});
                    end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        if (act.kind == ccc_pkg::ACT_FAIL)
        begin
            halted_next = 1'b1;
            phase_next  = PH_IDLE;
        end

        // Close an open token on the final byte
        if (end_of_file)
        begin
            if (act.kind == ccc_pkg::ACT_NONE && !halted_next)
            begin
                f = finish(phase_next, partial_next[23:16], pending_next);
                if (in_token(phase_next))
                    phase_next = PH_IDLE;
                act = f;
            end
            halted_next = 1'b1;
        end

        if (halted_reg)
        begin
            act.kind     = ccc_pkg::ACT_NONE;
            phase_next   = phase_reg;
            partial_next = partial_reg;
            pending_next = pending_reg;
            wide_next    = wide_reg;
            halted_next  = halted_reg;
        end
    end

    assign action = act;

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            partial_reg <= 24'h0;
            pending_reg <= 9'h0;
            wide_reg    <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            wide_reg    <= wide_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

@@ src/ccc_cell.sv @@
module ccc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  ccc_pkg::probe_t  probe_in,
    output ccc_pkg::probe_t  probe_out
);

    logic [23:0]     code_reg;
    logic            occupied;
    logic            match;
    logic            store;
    ccc_pkg::probe_t probe_reg, probe_next;

    // A cell is occupied while the probe still has filled slots ahead of it
    assign occupied = probe_in.remaining != '0;
    assign match    = occupied && (code_reg == probe_in.code);
    assign store    = probe_in.valid && !occupied && !probe_in.hit && !probe_in.placed;

    always_comb
    begin
        probe_next           = probe_in;
        probe_next.hit       = probe_in.hit | match;
        probe_next.placed    = probe_in.placed | store;
        probe_next.remaining = occupied ? probe_in.remaining - ccc_pkg::CNT_W'(1)
                                        : probe_in.remaining;
    end

    // Hold the stored code; write it when the probe claims this slot
    always_ff @(posedge clk)
    begin
        if (store)
            code_reg <= probe_in.code;
    end

    // Hand the probe to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= '0;
        else
            probe_reg <= probe_next;
    end

    assign probe_out = probe_reg;

endmodule

@@ src/ccc_row.sv @@
module ccc_row (
    input  logic             clk,
    input  logic             rst_n,
    input  ccc_pkg::probe_t  probe_in,
    output ccc_pkg::probe_t  probe_out
);

    ccc_pkg::probe_t link [ccc_pkg::TABLE_DEPTH+1];

    assign link[0] = probe_in;

    // Chain the table cells, slot 0 first
    for (genvar i = 0; i < ccc_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        ccc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (link[i]),
            .probe_out (link[i+1])
        );
    end

    assign probe_out = link[ccc_pkg::TABLE_DEPTH];

endmodule

@@ src/charset_text_code_collector.sv @@
// Channel  Dir  Fields
// s_*      in   tdata[7:0] in_byte, tlast end_of_file
// m_*      out  tdata[23:0] packed_code, tdata[33:24] stored_count; tuser[2:0] outcome
//
// A byte that asks for a table store sends a probe down a row of TABLE_DEPTH
// cells, one cell per cycle. One byte is handled at a time; s_tready stays low
// while a probe is in the row or a result waits on m_*. Reset clears the parser
// and the entry count; table cells need no clearing since only filled slots are
// compared.
module charset_text_code_collector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [23:0] packed_code, [33:24] stored_count, zero pad
    output logic [2:0]  m_tuser    // [2:0] outcome
);

    logic                      s_accept;
    ccc_pkg::action_t          action;
    ccc_pkg::probe_t           launch_reg;
    ccc_pkg::probe_t           row_out;
    logic                      busy_reg;
    logic [ccc_pkg::CNT_W-1:0] count_reg;
    logic                      out_valid_reg;
    logic [23:0]               out_code_reg;
    logic [2:0]                out_kind_reg;
    logic [ccc_pkg::CNT_W-1:0] out_count_reg;

    assign s_tready = !busy_reg && !out_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    ccc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s_accept),
        .in_byte     (s_tdata),
        .end_of_file (s_tlast),
        .action      (action)
    );

    ccc_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe_in  (launch_reg),
        .probe_out (row_out)
    );

    // Launch probes, track occupancy and load results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= '0;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg.valid <= s_accept && action.kind == ccc_pkg::ACT_ADD;

            if (s_accept && action.kind == ccc_pkg::ACT_ADD)
            begin
                launch_reg.code      <= action.code;
                launch_reg.hit       <= 1'b0;
                launch_reg.placed    <= 1'b0;
                launch_reg.remaining <= count_reg;
                busy_reg             <= 1'b1;
            end
            else if (row_out.valid)
            begin
                busy_reg <= 1'b0;
            end

            if (s_accept && action.kind == ccc_pkg::ACT_FAIL)
                out_valid_reg <= 1'b1;
            else if (row_out.valid && !row_out.hit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            if (row_out.valid && !row_out.hit && row_out.placed)
                count_reg <= count_reg + ccc_pkg::CNT_W'(1);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s_accept && action.kind == ccc_pkg::ACT_FAIL)
        begin
            out_code_reg  <= 24'h0;
            out_kind_reg  <= action.outcome;
            out_count_reg <= count_reg;
        end
        else if (row_out.valid && !row_out.hit)
        begin
            out_code_reg  <= row_out.code;
            out_kind_reg  <= row_out.placed ? ccc_pkg::OUT_NEW : ccc_pkg::OUT_FULL;
            out_count_reg <= row_out.placed ? count_reg + ccc_pkg::CNT_W'(1) : count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'h00, out_count_reg, out_code_reg};
    assign m_tuser  = out_kind_reg;

endmodule
